// ===== rtl/bfnc_pkg.sv =====
// Shared types and constants of the bit set find-next and count block.
// Used by bfnc_ctrl, bfnc_dpath and the top level; depends on nothing.
`default_nettype none

package bfnc_pkg;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned ELEM_W     = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned BIT_SEL_W  = $clog2(WORD_BITS);

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic [WORD_BITS-1:0] M_EVEN  = 64'h5555555555555555;
  localparam logic [WORD_BITS-1:0] M_PAIR  = 64'h3333333333333333;
  localparam logic [WORD_BITS-1:0] M_NIBL  = 64'h0f0f0f0f0f0f0f0f;
  localparam logic [WORD_BITS-1:0] M_LOW32 = 64'h00000000ffffffff;

  // Trailing zero count of a nibble; the all-zero nibble counts as four.
  localparam logic [2:0] LOW_NIBBLE_ZEROS [16] = '{
    3'd4, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0,
    3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0
  };

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET       = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_FIND      = 3'd2,
    ACT_COUNT     = 3'd3,
    ACT_CLEAR_ALL = 3'd4
  } bfnc_action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture an accepted item
    logic rd;         // read the word at the pointer
    logic ptr_inc;    // advance the word pointer
    logic wr_modify;  // write back the read word with one bit set or cleared
    logic wr_zero;    // write zero at the pointer
    logic scan;       // examine the read word for a find
    logic pop_en;     // take the population count of the read word
    logic locate;     // resolve the bit position inside the hit word
    logic err_set;    // flag a range error
    logic out_load;   // move the result into the output register
  } bfnc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                start_ok;   // element lies inside the active words
    logic                hit;        // read word has a set bit at or after start
    logic                rd_last;    // read word is the last active word
    logic                ptr_last;   // pointer is at the last active word
    logic                init_last;  // pointer is at the last physical word
    logic                out_busy;   // output holds an item that is not taken
  } bfnc_status_t;

endpackage

`default_nettype wire

// ===== rtl/bfnc_ctrl.sv =====
// Controller state machine of the bit set block: sequences the clearing pass,
// decodes each item and steps the datapath. Depends on bfnc_pkg.
`default_nettype none

module bfnc_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  bfnc_pkg::bfnc_status_t status_i,
  output bfnc_pkg::bfnc_cmd_t    cmd_o
);
  import bfnc_pkg::*;

  typedef enum logic [9:0] {
    ST_INIT     = 10'b0000000001,
    ST_IDLE     = 10'b0000000010,
    ST_DECODE   = 10'b0000000100,
    ST_MODIFY   = 10'b0000001000,
    ST_SCAN     = 10'b0000010000,
    ST_LOCATE   = 10'b0000100000,
    ST_COUNT    = 10'b0001000000,
    ST_CNT_TAIL = 10'b0010000000,
    ST_WIPE     = 10'b0100000000,
    ST_RESULT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (status_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status_i.action) inside
          ACT_SET, ACT_CLEAR: begin
            if (status_i.start_ok) begin
              cmd_o.rd = 1'b1;
              state_d  = ST_MODIFY;
            end else begin
              cmd_o.err_set = 1'b1;
              state_d       = ST_RESULT;
            end
          end
          ACT_FIND: begin
            if (status_i.start_ok) begin
              cmd_o.rd      = 1'b1;
              cmd_o.ptr_inc = 1'b1;
              state_d       = ST_SCAN;
            end else begin
              state_d = ST_RESULT;
            end
          end
          ACT_COUNT: begin
            cmd_o.rd      = 1'b1;
            cmd_o.ptr_inc = 1'b1;
            state_d       = ST_COUNT;
          end
          ACT_CLEAR_ALL: begin
            state_d = ST_WIPE;
          end
          default: begin
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_MODIFY: begin
        cmd_o.wr_modify = 1'b1;
        state_d         = ST_RESULT;
      end
      ST_SCAN: begin
        cmd_o.scan    = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (status_i.hit) begin
          state_d = ST_LOCATE;
        end else if (status_i.rd_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_LOCATE: begin
        cmd_o.locate = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_COUNT: begin
        cmd_o.pop_en  = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_CNT_TAIL;
        end
      end
      ST_CNT_TAIL: begin
        // The count of the last word is added in this cycle.
        state_d = ST_RESULT;
      end
      ST_WIPE: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (status_i.ptr_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bfnc_dpath.sv =====
// Datapath of the bit set block: word memory, word pointer, find and count
// logic, configuration register and output register. Depends on bfnc_pkg.
`default_nettype none

module bfnc_dpath #(
  parameter int unsigned MAX_WORDS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire  [bfnc_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire  [bfnc_pkg::ACTION_W-1:0]      item_action_i,
  input  wire  [bfnc_pkg::ELEM_W-1:0]        item_elem_i,
  input  bfnc_pkg::bfnc_cmd_t                cmd_i,
  output bfnc_pkg::bfnc_status_t             status_o,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_found_o,
  output logic [bfnc_pkg::ELEM_W-1:0]        out_pos_o,
  output logic [bfnc_pkg::CNT_W-1:0]         out_cnt_o,
  output logic                               out_err_o
);
  import bfnc_pkg::*;

  localparam int unsigned WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned PTR_W  = $clog2(MAX_WORDS + 1);
  localparam int unsigned CMP_W  = (PTR_W > CFG_W) ? PTR_W : CFG_W;
  localparam int unsigned POP_W  = $clog2(WORD_BITS + 1);

  function automatic logic [POP_W-1:0] pop_word(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    v = (w & M_EVEN) + ((w >> 1) & M_EVEN);
    v = (v & M_PAIR) + ((v >> 2) & M_PAIR);
    v = (v & M_NIBL) + ((v >> 4) & M_NIBL);
    v = v + (v >> 8);
    v = v + (v >> 16);
    v = v + (v >> 32);
    return v[POP_W-1:0];
  endfunction

  function automatic logic [BIT_SEL_W-1:0] lowest_one(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [BIT_SEL_W-1:0] n;
    v = w;
    n = '0;
    if ((v & M_LOW32) == '0) begin
      n = n + BIT_SEL_W'(32);
      v = v >> 32;
    end
    if (v[15:0] == '0) begin
      n = n + BIT_SEL_W'(16);
      v = v >> 16;
    end
    if (v[7:0] == '0) begin
      n = n + BIT_SEL_W'(8);
      v = v >> 8;
    end
    if (v[3:0] == '0) begin
      n = n + BIT_SEL_W'(4);
      v = v >> 4;
    end
    return n + BIT_SEL_W'(LOW_NIBBLE_ZEROS[v[3:0]]);
  endfunction

  // Configuration and the active word count derived from it.
  logic [CFG_W-1:0] cfg_q;
  logic [CMP_W-1:0] nw, nw_last, cfg_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    cfg_ext = CMP_W'(cfg_q);
    if (cfg_ext == '0) begin
      nw = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_WORDS)) begin
      nw = CMP_W'(MAX_WORDS);
    end else begin
      nw = cfg_ext;
    end
    nw_last = nw - CMP_W'(1);
  end

  // Item registers.
  logic [ACTION_W-1:0] action_q;
  logic [ELEM_W-1:0]   elem_q;
  logic [3:0]          start_word;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= item_action_i;
      elem_q   <= item_elem_i;
    end
  end

  assign start_word = elem_q[ELEM_W-1:BIT_SEL_W];

  // Word pointer and the index of the word held in the read register.
  logic [PTR_W-1:0] ptr_q, ptr_d, rd_word_q;
  logic             rd_en;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      if (item_action_i == ACT_COUNT || item_action_i == ACT_CLEAR_ALL) begin
        ptr_d = '0;
      end else begin
        ptr_d = PTR_W'(item_elem_i[ELEM_W-1:BIT_SEL_W]);
      end
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // The scan runs one word ahead, so never read past the last physical word.
  assign rd_en = cmd_i.rd && (ptr_q < PTR_W'(MAX_WORDS));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_word_q <= ptr_q;
    end
  end

  // Word memory with one shared address.
  logic [WORD_BITS-1:0] mem_q [MAX_WORDS];
  logic [WORD_BITS-1:0] rdata_q, wdata, bit_mask;
  logic                 wr_en;
  logic [WIDX_W-1:0]    addr;

  assign addr     = ptr_q[WIDX_W-1:0];
  assign bit_mask = WORD_BITS'(1) << elem_q[BIT_SEL_W-1:0];
  assign wr_en    = cmd_i.wr_zero || cmd_i.wr_modify;

  always_comb begin
    if (cmd_i.wr_zero) begin
      wdata = '0;
    end else if (action_q == ACT_SET) begin
      wdata = rdata_q | bit_mask;
    end else begin
      wdata = rdata_q & ~bit_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Find: the first word examined ignores bits below the start element.
  logic                 first_q;
  logic [WORD_BITS-1:0] scan_mask, masked, hit_word_q;
  logic [PTR_W-1:0]     hit_idx_q;
  logic                 hit;

  assign scan_mask = first_q ? ({WORD_BITS{1'b1}} << elem_q[BIT_SEL_W-1:0])
                             : {WORD_BITS{1'b1}};
  assign masked    = rdata_q & scan_mask;
  assign hit       = masked != '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q <= 1'b1;
    end else if (cmd_i.scan) begin
      first_q <= 1'b0;
    end
    if (cmd_i.scan && hit) begin
      hit_word_q <= masked;
      hit_idx_q  <= rd_word_q;
    end
  end

  // Count: population count is registered, then added with saturation.
  logic [POP_W-1:0] pop_q;
  logic             pop_vld_q;
  logic [CNT_W:0]   acc_sum;
  logic [CNT_W-1:0] acc_q;

  assign acc_sum = {1'b0, acc_q} + (CNT_W + 1)'(pop_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_vld_q <= 1'b0;
    end else begin
      pop_vld_q <= cmd_i.pop_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_en) begin
      pop_q <= pop_word(rdata_q);
    end
  end

  // Result registers of the item in work.
  logic             res_found_q, res_err_q;
  logic [ELEM_W-1:0] res_pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_found_q <= 1'b0;
      res_err_q   <= 1'b0;
      res_pos_q   <= '0;
      acc_q       <= '0;
    end else begin
      if (cmd_i.err_set) begin
        res_err_q <= 1'b1;
      end
      if (cmd_i.locate) begin
        res_found_q <= 1'b1;
        res_pos_q   <= ELEM_W'({hit_idx_q, lowest_one(hit_word_q)});
      end
      if (pop_vld_q) begin
        acc_q <= acc_sum[CNT_W] ? CNT_MAX : acc_sum[CNT_W-1:0];
      end
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_o <= res_found_q;
      out_pos_o   <= res_pos_q;
      out_cnt_o   <= acc_q;
      out_err_o   <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.action    = action_q;
    status_o.start_ok  = CMP_W'(start_word) < nw;
    status_o.hit       = hit;
    status_o.rd_last   = CMP_W'(rd_word_q) == nw_last;
    status_o.ptr_last  = CMP_W'(ptr_q) == nw_last;
    status_o.init_last = ptr_q == PTR_W'(MAX_WORDS - 1);
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

// ===== rtl/bitset_find_next_and_count.sv =====
// Bit set with set, clear, find-next-set, count and clear-all actions.
//
// Items enter on the s_axis channel: tuser carries the action, tdata the
// element index. Every item gives one result item on the m_axis channel. The
// user writes the active size on the cfg channel only while the block idles.
//
// The block itself does not enforce the idle rule for the cfg channel. A set
// or clear reads the addressed word and writes it back; a find reads the
// active words from the word of the start element on until a set element
// turns up or the last active word is examined; a count reads every active
// word; clear all writes zero to every active word. An out-of-range set or
// clear, an unknown action and a find starting outside the set touch no
// word. The word memory has a single port, which serves one word per cycle.
// One item is in work at a time; the next one is taken while a finished
// result waits in the output register.
//
// After reset the block clears all MAX_WORDS words, one per cycle, before it
// takes the first item; configuration writes are taken at any time. When the
// receiver stalls, the result holds and the block stops after the next item.
`default_nettype none

module bitset_find_next_and_count #(
  parameter int unsigned MAX_WORDS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: words_in_use.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [4:0]  cfg_data_i,
  // Input items.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [9:0] element_index, [15:10] zero
  input  wire  [2:0]  s_axis_tuser,   // [2:0] action
  // Result items.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] found_position, [20:10] set_count,
                                      // [23:21] zero
  output logic [1:0]  m_axis_tuser    // [0] found, [1] range_error
);
  import bfnc_pkg::*;

  bfnc_cmd_t    cmd;
  bfnc_status_t status;

  logic              out_found, out_err;
  logic [ELEM_W-1:0] out_pos;
  logic [CNT_W-1:0]  out_cnt;

  assign cfg_ready_o = 1'b1;

  bfnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bfnc_dpath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .item_action_i (s_axis_tuser),
    .item_elem_i   (s_axis_tdata[ELEM_W-1:0]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_found_o   (out_found),
    .out_pos_o     (out_pos),
    .out_cnt_o     (out_cnt),
    .out_err_o     (out_err)
  );

  assign m_axis_tdata = {3'b000, out_cnt, out_pos};
  assign m_axis_tuser = {out_err, out_found};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for bitset_find_next_and_count: directed and random items,
// each result checked field by field against a behavioral bit set kept here.
// Depends on bfnc_pkg and the block's RTL; needs no other file.
`timescale 1ns / 100ps

module testbench;
  import bfnc_pkg::*;

  localparam int unsigned NUM_WORDS   = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 160;
  // Slowest actions, a count or a find through every word, plus some margin.
  localparam int unsigned SETTLE      = 24;
  // Action codes the block does not define.
  localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_MID   = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = 3'd7;

  typedef struct packed {
    logic              found;
    logic [ELEM_W-1:0] position;
    logic [CNT_W-1:0]  set_count;
    logic              range_error;
  } bitset_reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // [9:0] element_index, [15:10] zero
  logic [2:0]         s_axis_tuser;   // [2:0] action
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [23:0]        m_axis_tdata;   // [9:0] found_position, [20:10] set_count, [23:21] zero
  logic [1:0]         m_axis_tuser;   // [0] found, [1] range_error

  // Behavioral copy of the set and its size register.
  logic [WORD_BITS-1:0] set_words [NUM_WORDS];
  logic [CFG_W-1:0]     words_setting;
  bitset_reply_t        owed_replies [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idle_enable;
  bit          hold_off_req;

  bitset_find_next_and_count #(
    .MAX_WORDS(NUM_WORDS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int active_words();
    if (words_setting == 0) return 1;
    if (words_setting > NUM_WORDS) return NUM_WORDS;
    return int'(words_setting);
  endfunction

  // Applies one action to the set and returns the reply it must produce.
  function automatic bitset_reply_t next_bitset_reply(logic [ACTION_W-1:0] act,
                                                      logic [ELEM_W-1:0] elem);
    bitset_reply_t reply;
    int nw;
    int total;
    reply = '0;
    nw    = active_words();
    total = 0;
    case (act)
      ACT_SET, ACT_CLEAR: begin
        if (int'(elem) >= nw * WORD_BITS) begin
          reply.range_error = 1'b1;
        end else begin
          set_words[elem / WORD_BITS][elem % WORD_BITS] = (act == ACT_SET);
        end
      end
      ACT_FIND: begin
        if (int'(elem) < nw * WORD_BITS) begin
          for (int e = int'(elem); e < nw * WORD_BITS; e++) begin
            if (!reply.found && set_words[e / WORD_BITS][e % WORD_BITS]) begin
              reply.found    = 1'b1;
              reply.position = ELEM_W'(e);
            end
          end
        end
      end
      ACT_COUNT: begin
        for (int w = 0; w < nw; w++) total += $countones(set_words[w]);
        reply.set_count = (total > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(total);
      end
      ACT_CLEAR_ALL: begin
        for (int w = 0; w < nw; w++) set_words[w] = '0;
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Offers one item, with an optional gap first, and records its reply once taken.
  // tvalid stays high afterwards, so that back-to-back items are offered without dropping it.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ELEM_W-1:0] elem);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, elem};
    do @(posedge clk_i); while (!s_axis_tready);
    owed_replies.push_back(next_bitset_reply(act, elem));
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_words_in_use(input logic [CFG_W-1:0] value);
    drain_replies();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    words_setting = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_basics();
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_SET, 10'd0);
    send_item(ACT_SET, 10'd1023);
    send_item(ACT_SET, 10'd63);
    send_item(ACT_SET, 10'd64);
    send_item(ACT_FIND, 10'd0);
    send_item(ACT_FIND, 10'd1);
    send_item(ACT_FIND, 10'd65);
    send_item(ACT_FIND, 10'd1023);
    send_item(ACT_COUNT, 10'd1023);
    send_item(ACT_CLEAR, 10'd63);
    send_item(ACT_FIND, 10'd1);
    send_item(ACT_UNDEF_FIRST, 10'd1023);
    send_item(ACT_UNDEF_MID, 10'd0);
    send_item(ACT_UNDEF_LAST, 10'd512);
    send_item(ACT_CLEAR, 10'd0);
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_CLEAR_ALL, 10'd0);
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_FIND, 10'd0);
  endtask

  // One word, zero (acts as one), and sizes above the maximum (act as the maximum).
  task automatic test_word_limits();
    write_words_in_use(5'd1);
    send_item(ACT_SET, 10'd63);
    send_item(ACT_SET, 10'd64);
    send_item(ACT_CLEAR, 10'd700);
    send_item(ACT_FIND, 10'd63);
    send_item(ACT_FIND, 10'd64);
    send_item(ACT_SET, 10'd0);
    send_item(ACT_COUNT, 10'd0);
    write_words_in_use(5'd0);
    send_item(ACT_SET, 10'd64);
    send_item(ACT_FIND, 10'd1);
    write_words_in_use(5'd31);
    send_item(ACT_SET, 10'd1023);
    send_item(ACT_FIND, 10'd64);
    send_item(ACT_COUNT, 10'd0);
    write_words_in_use(5'd17);
    send_item(ACT_CLEAR, 10'd1023);
    send_item(ACT_COUNT, 10'd0);
  endtask

  // Clear all touches only the active words; the rest reappear when the size grows.
  task automatic test_inactive_words_kept();
    write_words_in_use(5'd16);
    send_item(ACT_SET, 10'd700);
    send_item(ACT_SET, 10'd1000);
    send_item(ACT_SET, 10'd5);
    write_words_in_use(5'd4);
    send_item(ACT_CLEAR_ALL, 10'd0);
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_FIND, 10'd0);
    write_words_in_use(5'd16);
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_FIND, 10'd0);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    idle_enable  = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item(bfnc_action_e'(i % 4), ELEM_W'($urandom_range(0, 1023)));
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 8; i++) send_item(ACT_SET, ELEM_W'($urandom_range(0, 1023)));
    drain_replies();
    send_item(ACT_COUNT, 10'd0);
    send_item(ACT_FIND, ELEM_W'($urandom_range(0, 1023)));
  endtask

  // Mostly in-range set, clear and find, so that finds land on real bits;
  // the rest is counts, clear all, undefined actions and any element at all.
  task automatic test_random_phase(input logic [CFG_W-1:0] size, input int n_items,
                                   input bit with_idle);
    int pick;
    int limit;
    write_words_in_use(size);
    idle_enable = with_idle;
    limit = active_words() * WORD_BITS - 1;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      send_item(ACT_SET, ELEM_W'($urandom_range(0, limit)));
      else if (pick < 50) send_item(ACT_CLEAR, ELEM_W'($urandom_range(0, limit)));
      else if (pick < 78) send_item(ACT_FIND, ELEM_W'($urandom_range(0, limit)));
      else if (pick < 88) send_item(ACT_COUNT, ELEM_W'($urandom_range(0, 1023)));
      else if (pick < 91) send_item(ACT_CLEAR_ALL, ELEM_W'($urandom_range(0, 1023)));
      else if (pick < 95) begin
        send_item(ACTION_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST)),
                  ELEM_W'($urandom_range(0, 1023)));
      end else begin
        send_item(ACTION_W'($urandom_range(ACT_SET, ACT_FIND)),
                  ELEM_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker and run timeout.
  initial begin
    bitset_reply_t want;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (owed_replies.size() == 0) begin
          $error("result item with none outstanding: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          if (m_axis_tuser[0] !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata[9:0] !== want.position) begin
            $error("found_position: expected %0d, actual %0d",
                   want.position, m_axis_tdata[9:0]);
            mismatches++;
          end
          if (m_axis_tdata[20:10] !== want.set_count) begin
            $error("set_count: expected %0d, actual %0d",
                   want.set_count, m_axis_tdata[20:10]);
            mismatches++;
          end
          if (m_axis_tuser[1] !== want.range_error) begin
            $error("range_error: expected %0d, actual %0d",
                   want.range_error, m_axis_tuser[1]);
            mismatches++;
          end
        end
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    mismatches    = 0;
    idle_enable   = 1'b1;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    words_setting = CFG_RESET;
    for (int w = 0; w < NUM_WORDS; w++) set_words[w] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_word_limits();
    test_inactive_words_kept();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_phase(5'd16, 75, 1'b1);
    test_random_phase(5'd1, 60, 1'b1);
    test_random_phase(5'd0, 40, 1'b1);
    test_random_phase(5'd31, 75, 1'b1);
    test_random_phase(CFG_W'($urandom_range(2, 15)), 75, 1'b1);
    test_random_phase(5'd17, 60, 1'b1);
    test_random_phase(CFG_W'($urandom_range(2, 15)), 75, 1'b1);
    // Closing stretch runs with both sides at full rate.
    test_random_phase(5'd16, 80, 1'b0);

    drain_replies();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && owed_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
